@@ rtl/fvm_pkg.sv @@
`timescale 1ns / 1ps
package fvm_pkg;

  localparam int DUTY_BITS    = 12;
  localparam int ANGLE_BITS   = 14;
  localparam int ANGLE_W      = 16;
  localparam int VOLT_W       = 16;
  localparam int PP_W         = 7;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int SEC_W        = 3;
  localparam int CS_W         = 18;
  localparam int CZ_W         = 17;
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_IDX_W = 4;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;

  localparam logic [DUTY_BITS-1:0]  DUTY_MAX  = '1;
  localparam logic [SEC_W-1:0]      SEC_NONE  = 3'd0;
  localparam logic [SEC_W-1:0]      SEC_LAST  = 3'd6;
  localparam logic signed [CS_W-1:0] CORDIC_X0 = 18'sd19898;

  localparam logic MODE_SPWM  = 1'b0;
  localparam logic MODE_SVPWM = 1'b1;

  localparam logic [PP_W-1:0]   RST_PP_COUNT = 7'd7;
  localparam logic [VOLT_W-1:0] RST_SUPPLY     = 16'd3072;
  localparam logic [ANGLE_W-1:0] RST_OFFSET    = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PP_COUNT   = 2'd0,
    REG_SUPPLY     = 2'd1,
    REG_OFFSET     = 2'd2,
    REG_MODE       = 2'd3
  } cfg_reg_t;

  typedef logic signed [VOLT_W-1:0] volt_t;

  typedef struct packed {
    logic [PP_W-1:0]    pp_count;
    logic [VOLT_W-1:0]  supply_voltage;
    logic [ANGLE_W-1:0] angle_offset;
    logic               mode;
  } cfg_t;

  // sideband carried with an angle through the sine/cosine pipeline
  typedef struct packed {
    logic [SEC_W-1:0] k;
    volt_t            uq;
  } tag_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    tag_t               tag;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // atan(2^-i) as a fraction of a turn
  function automatic logic signed [CZ_W-1:0] atan_turn(input logic [CORDIC_IDX_W-1:0] idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      4'd0:    v = 17'sd8192;
      4'd1:    v = 17'sd4836;
      4'd2:    v = 17'sd2555;
      4'd3:    v = 17'sd1297;
      4'd4:    v = 17'sd651;
      4'd5:    v = 17'sd326;
      4'd6:    v = 17'sd163;
      4'd7:    v = 17'sd81;
      4'd8:    v = 17'sd41;
      4'd9:    v = 17'sd20;
      4'd10:   v = 17'sd10;
      4'd11:   v = 17'sd5;
      4'd12:   v = 17'sd3;
      4'd13:   v = 17'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/fvm_in_if.sv @@
`timescale 1ns / 1ps
interface fvm_in_if;
  import fvm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_sample;
  logic signed [VOLT_W-1:0] voltage_target;
  modport source (output valid, angle_sample, voltage_target, input ready);
  modport sink   (input valid, angle_sample, voltage_target, output ready);
endinterface

@@ rtl/fvm_out_if.sv @@
`timescale 1ns / 1ps
interface fvm_out_if;
  import fvm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] duty_a;
  logic [DUTY_BITS-1:0] duty_b;
  logic [DUTY_BITS-1:0] duty_c;
  logic [SEC_W-1:0]     sector_number;
  logic                 clipped;
  modport source (output valid, duty_a, duty_b, duty_c, sector_number, clipped, input ready);
  modport sink   (input valid, duty_a, duty_b, duty_c, sector_number, clipped, output ready);
endinterface

@@ rtl/fvm_front.sv @@
`timescale 1ns / 1ps
module fvm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  fvm_pkg::cfg_t cfg,
  fvm_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output fvm_pkg::qitem_t push_item
);
  import fvm_pkg::*;

  localparam logic [ANGLE_W-1:0] RECIP6 = 16'd43691;
  localparam int RECIP6_SH = 18;

  logic                     en;
  logic [ANGLE_W-1:0]       mech;
  logic [ANGLE_W+PP_W-1:0]  elec_full;
  logic [ANGLE_W+2:0]       p6;
  logic [ANGLE_W:0]         vq;
  logic [2*ANGLE_W+1:0]     xin_full;
  logic [ANGLE_W-1:0]       xin;

  logic               f1_v_r;
  logic [ANGLE_W-1:0] f1_elec_r;
  volt_t              f1_uq_r;
  logic               f2_v_r;
  logic [ANGLE_W-1:0] f2_elec_r;
  logic [SEC_W-1:0]   f2_k_r;
  logic [ANGLE_W:0]   f2_vq_r;
  volt_t              f2_uq_r;

  assign en          = !(f2_v_r && q_full);
  assign in_ch.ready = en;

  // mechanical angle, then electrical angle, both wrapping to one turn
  assign mech      = (ANGLE_W'(in_ch.angle_sample) << (ANGLE_W - ANGLE_BITS)) + cfg.angle_offset;
  assign elec_full = (ANGLE_W+PP_W)'(mech) * (ANGLE_W+PP_W)'(cfg.pp_count);

  // sector split: 6*angle, integer part is the sector, fraction rounded over 6
  assign p6 = ((ANGLE_W+3)'(f1_elec_r) << 2) + ((ANGLE_W+3)'(f1_elec_r) << 1);
  assign vq = (ANGLE_W+1)'(p6[ANGLE_W-1:0]) + (ANGLE_W+1)'(3);

  assign xin_full = (2*ANGLE_W+2)'(f2_vq_r) * (2*ANGLE_W+2)'(RECIP6);
  assign xin      = xin_full[RECIP6_SH +: ANGLE_W];

  assign push              = f2_v_r && !q_full;
  assign push_item.angle   = (cfg.mode == MODE_SVPWM) ? xin : f2_elec_r;
  assign push_item.tag.k   = f2_k_r;
  assign push_item.tag.uq  = f2_uq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_ch.valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_elec_r <= elec_full[ANGLE_W-1:0];
      f1_uq_r   <= in_ch.voltage_target;
      f2_elec_r <= f1_elec_r;
      f2_k_r    <= p6[ANGLE_W+2:ANGLE_W];
      f2_vq_r   <= vq;
      f2_uq_r   <= f1_uq_r;
    end
  end

endmodule

@@ rtl/fvm_queue.sv @@
`timescale 1ns / 1ps
module fvm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fvm_pkg::qitem_t  push_item,
  input  logic             pop,
  output fvm_pkg::qitem_t  pop_item,
  output fvm_pkg::q_stat_t stat
);
  import fvm_pkg::*;

  qitem_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     cnt_r;

  assign stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + (QPTR_W+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ rtl/fvm_cordic.sv @@
`timescale 1ns / 1ps
module fvm_cordic (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [fvm_pkg::ANGLE_W-1:0] in_angle,
  input  fvm_pkg::tag_t             in_tag,
  output logic                      out_valid,
  output logic signed [fvm_pkg::CS_W-1:0] out_sin,
  output logic signed [fvm_pkg::CS_W-1:0] out_cos,
  output fvm_pkg::tag_t             out_tag
);
  import fvm_pkg::*;

  logic                   flip_in;
  logic [ANGLE_W-1:0]     a_adj;

  logic [CORDIC_STEPS:0]  v_r;
  logic signed [CS_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CS_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0] z_r [CORDIC_STEPS+1];
  logic                   flip_r [CORDIC_STEPS+1];
  tag_t                   tag_r [CORDIC_STEPS+1];
  logic                   o_v_r;

  // second and third quadrants rotate by half a turn and negate at the end
  assign flip_in = in_angle[ANGLE_W-1] ^ in_angle[ANGLE_W-2];
  assign a_adj   = in_angle ^ {flip_in, (ANGLE_W-1)'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      o_v_r <= 1'b0;
    end else if (en) begin
      v_r   <= {v_r[CORDIC_STEPS-1:0], in_valid};
      o_v_r <= v_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_X0;
      y_r[0]    <= '0;
      z_r[0]    <= CZ_W'($signed(a_adj));
      flip_r[0] <= flip_in;
      tag_r[0]  <= in_tag;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CS_W-1:0] dx;
    logic signed [CS_W-1:0] dy;
    logic signed [CZ_W-1:0] ang;
    assign dx  = y_r[i] >>> i;
    assign dy  = x_r[i] >>> i;
    assign ang = atan_turn(CORDIC_IDX_W'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][CZ_W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ang;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ang;
        end
        flip_r[i+1] <= flip_r[i];
        tag_r[i+1]  <= tag_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sin <= flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
      out_cos <= flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      out_tag <= tag_r[CORDIC_STEPS];
    end
  end

  assign out_valid = o_v_r;

endmodule

@@ rtl/fvm_back.sv @@
`timescale 1ns / 1ps
module fvm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  fvm_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  fvm_pkg::qitem_t q_item,
  output logic            pop,
  fvm_out_if.source       out_ch
);
  import fvm_pkg::*;

  localparam int PW    = 40;
  localparam int NW    = 60;
  localparam int DIV_W = DUTY_BITS + VOLT_W;
  localparam int NPH   = 3;
  localparam logic signed [18:0] C_1P5  = 19'sd98304;
  localparam logic signed [18:0] C_SQ3H = 19'sd56756;
  localparam logic signed [18:0] C_SQ3  = 19'sd113512;
  localparam logic [NW-1:0] DMAX2 = NW'(2) * NW'(DUTY_MAX);

  logic                en;
  logic                take;
  logic [VOLT_W-1:0]   vs;
  logic signed [PW-1:0] vs_d;
  logic signed [PW-1:0] vs_2d;

  logic                   cs_v;
  logic signed [CS_W-1:0] cs_sin;
  logic signed [CS_W-1:0] cs_cos;
  tag_t                   cs_tag;

  // stage 1
  logic signed [CS_W+VOLT_W-1:0] m_su;
  logic signed [CS_W+VOLT_W-1:0] m_cu;
  logic signed [CS_W+18:0]       m_c15;
  logic signed [CS_W+18:0]       m_s866;
  logic signed [CS_W+18:0]       m_s173;
  logic signed [CS_W+19:0]       sv_a;
  logic signed [CS_W+19:0]       sv_b;
  logic                 p1_v_r;
  logic signed [PW-1:0] p1_pa_r;
  logic signed [PW-1:0] p1_pb_r;
  tag_t                 p1_tag_r;

  // stage 2
  logic signed [52:0]   m_ub;
  logic signed [53:0]   ub_sum;
  logic signed [19:0]   a1;
  logic signed [19:0]   a2;
  logic signed [35:0]   m_a1;
  logic signed [35:0]   m_a2;
  logic                 p2_v_r;
  logic signed [PW-1:0] p2_r0_r;
  logic signed [PW-1:0] p2_r1_r;
  logic [SEC_W-1:0]     p2_k_r;

  // stage 3
  logic signed [PW-1:0] t1;
  logic signed [PW-1:0] t2;
  logic signed [PW-1:0] h0;
  logic signed [PW-1:0] uc;
  logic signed [PW-1:0] num [NPH];
  logic                 p3_v_r;
  logic signed [PW-1:0] p3_num_r [NPH];
  logic [SEC_W-1:0]     p3_sec_r;

  // divider stages, index 0 is the scaled dividend
  logic [DUTY_BITS:0]   dv_r;
  logic [DIV_W-1:0]     rem_r [DUTY_BITS+1][NPH];
  logic [DUTY_BITS-1:0] q_r   [DUTY_BITS+1][NPH];
  logic                 lo_r  [DUTY_BITS+1][NPH];
  logic                 hi_r  [DUTY_BITS+1][NPH];
  logic [SEC_W-1:0]     sec_r [DUTY_BITS+1];

  logic                 out_v_r;
  logic [DUTY_BITS-1:0] duty_r [NPH];
  logic [SEC_W-1:0]     sec_out_r;
  logic                 clip_out_r;
  logic [DUTY_BITS-1:0] duty_nxt [NPH];
  logic                 clip_nxt;

  assign en   = !out_v_r || out_ch.ready;
  assign take = !q_empty;
  assign pop  = take && en;

  assign vs    = (cfg.supply_voltage == '0) ? VOLT_W'(1) : cfg.supply_voltage;
  assign vs_d  = $signed(PW'(vs) << 15);
  assign vs_2d = $signed(PW'(vs) << 16);

  fvm_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (take),
    .in_angle  (q_item.angle),
    .in_tag    (q_item.tag),
    .out_valid (cs_v),
    .out_sin   (cs_sin),
    .out_cos   (cs_cos),
    .out_tag   (cs_tag)
  );

  // stage 1: spwm alpha/beta products, or svpwm sector times
  assign m_su   = cs_sin * cs_tag.uq;
  assign m_cu   = cs_cos * cs_tag.uq;
  assign m_c15  = cs_cos * C_1P5;
  assign m_s866 = cs_sin * C_SQ3H;
  assign m_s173 = cs_sin * C_SQ3;
  assign sv_a   = (CS_W+20)'(m_c15) - (CS_W+20)'(m_s866) + (CS_W+20)'(32768);
  assign sv_b   = (CS_W+20)'(m_s173) + (CS_W+20)'(32768);

  // stage 2: phase b voltage, or sector times scaled by uq
  assign m_ub   = $signed(p1_pb_r[33:0]) * C_SQ3H;
  assign ub_sum = 54'(m_ub) + (54'(p1_pa_r) <<< 15) + 54'(32768);
  assign a1     = $signed(p1_pa_r[16 +: 20]);
  assign a2     = $signed(p1_pb_r[16 +: 20]);
  assign m_a1   = a1 * p1_tag_r.uq;
  assign m_a2   = a2 * p1_tag_r.uq;

  // stage 3: per-phase numerators on a common denominator of vs * 2^17
  assign t1 = p2_r0_r <<< 1;
  assign t2 = p2_r1_r <<< 1;
  assign h0 = vs_d - p2_r0_r - p2_r1_r;
  assign uc = -(p2_r0_r + p2_r1_r);

  always_comb begin
    if (cfg.mode == MODE_SPWM) begin
      num[0] = t1 + vs_2d;
      num[1] = t2 + vs_2d;
      num[2] = (uc <<< 1) + vs_2d;
    end else begin
      case (p2_k_r)
        3'd0: begin
          num[0] = t1 + t2 + h0; num[1] = t2 + h0;      num[2] = h0;
        end
        3'd1: begin
          num[0] = t1 + h0;      num[1] = t1 + t2 + h0; num[2] = h0;
        end
        3'd2: begin
          num[0] = h0;           num[1] = t1 + t2 + h0; num[2] = t2 + h0;
        end
        3'd3: begin
          num[0] = h0;           num[1] = t1 + h0;      num[2] = t1 + t2 + h0;
        end
        3'd4: begin
          num[0] = t2 + h0;      num[1] = h0;           num[2] = t1 + t2 + h0;
        end
        default: begin
          num[0] = t1 + t2 + h0; num[1] = h0;           num[2] = t1 + h0;
        end
      endcase
      num[0] = num[0] + vs_2d;
      num[1] = num[1] + vs_2d;
      num[2] = num[2] + vs_2d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      dv_r    <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r  <= cs_v;
      p2_v_r  <= p1_v_r;
      p3_v_r  <= p2_v_r;
      dv_r    <= {dv_r[DUTY_BITS-1:0], p3_v_r};
      out_v_r <= dv_r[DUTY_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_tag_r <= cs_tag;
      if (cfg.mode == MODE_SPWM) begin
        p1_pa_r <= PW'(m_su);
        p1_pb_r <= PW'(m_cu);
        p2_r0_r <= -p1_pa_r;
        p2_r1_r <= PW'(ub_sum >>> 16);
      end else begin
        p1_pa_r <= PW'(sv_a);
        p1_pb_r <= PW'(sv_b);
        p2_r0_r <= PW'(m_a1);
        p2_r1_r <= PW'(m_a2);
      end
      p2_k_r   <= p1_tag_r.k;
      p3_num_r <= num;
      p3_sec_r <= (cfg.mode == MODE_SVPWM) ? p2_k_r + SEC_W'(1) : SEC_NONE;
      sec_r[0] <= p3_sec_r;
    end
  end

  for (genvar p = 0; p < NPH; p++) begin : g_ph
    logic signed [NW-1:0] n_full;
    logic signed [NW-1:0] n_sh;
    logic signed [NW-1:0] n_lim;
    logic                 lo;
    logic                 hi;
    assign n_full = NW'(p3_num_r[p]) * $signed(DMAX2) + $signed(NW'(vs) << 17);
    assign n_sh   = n_full >>> 18;
    assign n_lim  = $signed(NW'(vs) << DUTY_BITS);
    assign lo     = n_sh[NW-1];
    assign hi     = !lo && (n_sh >= n_lim);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0][p] <= (lo || hi) ? '0 : n_sh[DIV_W-1:0];
        q_r[0][p]   <= '0;
        lo_r[0][p]  <= lo;
        hi_r[0][p]  <= hi;
      end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < DUTY_BITS; j++) begin : g_div
      localparam int B = DUTY_BITS - 1 - j;
      logic [DIV_W:0] trial;
      assign trial = (DIV_W+1)'(rem_r[j][p]) - ((DIV_W+1)'(vs) << B);
      always_ff @(posedge clk) begin
        if (en) begin
          if (!trial[DIV_W]) begin
            rem_r[j+1][p] <= trial[DIV_W-1:0];
            q_r[j+1][p]   <= q_r[j][p] | (DUTY_BITS'(1) << B);
          end else begin
            rem_r[j+1][p] <= rem_r[j][p];
            q_r[j+1][p]   <= q_r[j][p];
          end
          lo_r[j+1][p] <= lo_r[j][p];
          hi_r[j+1][p] <= hi_r[j][p];
        end
      end
    end

    assign duty_nxt[p] = hi_r[DUTY_BITS][p] ? DUTY_MAX :
                         lo_r[DUTY_BITS][p] ? '0 : q_r[DUTY_BITS][p];
  end

  for (genvar j = 0; j < DUTY_BITS; j++) begin : g_sec
    always_ff @(posedge clk) begin
      if (en) sec_r[j+1] <= sec_r[j];
    end
  end

  assign clip_nxt = lo_r[DUTY_BITS][0] || hi_r[DUTY_BITS][0] ||
                    lo_r[DUTY_BITS][1] || hi_r[DUTY_BITS][1] ||
                    lo_r[DUTY_BITS][2] || hi_r[DUTY_BITS][2];

  always_ff @(posedge clk) begin
    if (en) begin
      duty_r     <= duty_nxt;
      sec_out_r  <= sec_r[DUTY_BITS];
      clip_out_r <= clip_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.duty_a        = duty_r[0];
  assign out_ch.duty_b        = duty_r[1];
  assign out_ch.duty_c        = duty_r[2];
  assign out_ch.sector_number = sec_out_r;
  assign out_ch.clipped       = clip_out_r;

endmodule

@@ rtl/foc_voltage_modulator.sv @@
`timescale 1ns / 1ps
// FOC voltage modulator: turns a rotor angle sample and a q-axis voltage target into
// three PWM duties, by inverse Park/Clarke (sinusoidal) or by sector-based space vector
// modulation, chosen by the mode register. One transfer is taken every clock cycle
// while the queue has room; each result passes through the 14-step sine/cosine
// pipeline and the 12-stage duty divider (one stage per duty bit). A four-entry queue
// sits between the angle front end and the modulation back end, so a stalled output
// lets the front keep taking transfers until the queue fills. Write the configuration
// registers only while no transfer is in flight.
module foc_voltage_modulator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fvm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [fvm_pkg::CFG_W-1:0]       cfg_wdata,
  fvm_in_if.sink                          in_ch,
  fvm_out_if.source                       out_ch
);
  import fvm_pkg::*;

  // configuration registers
  logic [PP_W-1:0]    pp_count_r;
  logic [VOLT_W-1:0]  supply_r;
  logic [ANGLE_W-1:0] offset_r;
  logic               mode_r;
  cfg_t               cfg;

  // front to queue to back
  logic    q_push;
  logic    q_pop;
  qitem_t  q_in;
  qitem_t  q_out;
  q_stat_t q_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_count_r   <= RST_PP_COUNT;
      supply_r     <= RST_SUPPLY;
      offset_r     <= RST_OFFSET;
      mode_r       <= MODE_SPWM;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_PP_COUNT:   pp_count_r   <= cfg_wdata[PP_W-1:0];
        REG_SUPPLY:     supply_r     <= cfg_wdata[VOLT_W-1:0];
        REG_OFFSET:     offset_r     <= cfg_wdata[ANGLE_W-1:0];
        REG_MODE:       mode_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.pp_count       = pp_count_r;
  assign cfg.supply_voltage = supply_r;
  assign cfg.angle_offset   = offset_r;
  assign cfg.mode           = mode_r;

  // front: angle offset, pole pair scaling, sector split
  fvm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .q_full    (q_st.full),
    .push      (q_push),
    .push_item (q_in)
  );

  fvm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .stat      (q_st)
  );

  // back: sine/cosine, modulation, duty division, output register
  fvm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_st.empty),
    .q_item  (q_out),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // queue never written when full, never read when empty
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_st.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty) else $error("queue read while empty");

  // sector code follows the modulation mode
  a_spwm_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && mode_r == MODE_SPWM) |-> out_ch.sector_number == SEC_NONE)
    else $error("sector set in sinusoidal mode");

  a_svpwm_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && mode_r == MODE_SVPWM) |->
      (out_ch.sector_number != SEC_NONE && out_ch.sector_number <= SEC_LAST))
    else $error("sector out of range in space vector mode");

endmodule
